[rtl/hgf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgf_pkg
// Shared constants, types and controller/datapath interface for the HSV grid
// fade and LED render core.
// ----------------------------------------------------------------------------
package hgf_pkg;

   localparam int GRID_WIDTH  = 8;
   localparam int GRID_HEIGHT = 8;
   localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
   localparam int X_W         = $clog2(GRID_WIDTH);
   localparam int Y_W         = $clog2(GRID_HEIGHT);
   localparam int ADDR_W      = $clog2(CELLS);
   localparam int STEP_W      = 24;
   localparam int MAG_W       = STEP_W - 1;
   localparam int DCNT_W      = $clog2(MAG_W);

   localparam logic [1:0] MODE_WRITE  = 2'd0;
   localparam logic [1:0] MODE_TICK   = 2'd1;
   localparam logic [1:0] MODE_RENDER = 2'd2;

   typedef enum logic [1:0] {
      RD_ITEM   = 2'd0,
      RD_COUNT  = 2'd1,
      RD_CORNER = 2'd2
   } rd_src_type;

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_DECODE = 14'b00000000000010,
      ST_WR_RD  = 14'b00000000000100,
      ST_WR_DIV = 14'b00000000001000,
      ST_WR_WT  = 14'b00000000010000,
      ST_TK_RD  = 14'b00000000100000,
      ST_TK_MUL = 14'b00000001000000,
      ST_TK_WR  = 14'b00000010000000,
      ST_RN_RD  = 14'b00000100000000,
      ST_RN_MAC = 14'b00001000000000,
      ST_HSV1   = 14'b00010000000000,
      ST_HSV2   = 14'b00100000000000,
      ST_HSV3   = 14'b01000000000000,
      ST_FIN    = 14'b10000000000000
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       wr_direct;
      logic       rd;
      rd_src_type rd_src;
      logic       div_start;
      logic       step_wr;
      logic       tk_mul;
      logic       tk_wr;
      logic       tk_end;
      logic       cnt_clr;
      logic       cnt_inc;
      logic       rn_wgt;
      logic       rn_mac;
      logic       acc_clr;
      logic       hsv1;
      logic       hsv2;
      logic       hsv3;
      logic       out_ld;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       len_zero;
      logic       fade_active;
      logic       px_zero;
      logic       div_busy;
      logic       cnt_last;
      logic       corner_last;
   } sts_type;

endpackage

[rtl/hgf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgf_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module hgf_div
   import hgf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [STEP_W-1:0] dividend,
   input  logic [7:0]               divisor,
   output logic signed [STEP_W-1:0] quotient,
   output logic                     busy
);

   logic              busy_ff, busy_in;
   logic              neg_ff, neg_in;
   logic [7:0]        d_ff, d_in;
   logic [7:0]        rem_ff, rem_in;
   logic [MAG_W-1:0]  quo_ff, quo_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [STEP_W-1:0] mag;
   logic [8:0]        trial;
   logic [8:0]        diff;
   logic              ge;

   always_comb begin
      mag     = dividend[STEP_W-1] ? (~dividend + 1'b1) : dividend;
      trial   = {rem_ff, quo_ff[MAG_W-1]};
      diff    = trial - {1'b0, d_ff};
      ge      = (trial >= {1'b0, d_ff});
      busy_in = busy_ff;
      neg_in  = neg_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[STEP_W-1];
         d_in    = divisor;
         rem_in  = '0;
         quo_in  = mag[MAG_W-1:0];
         cnt_in  = DCNT_W'(MAG_W - 1);
      end else if (busy_ff) begin
         quo_in = {quo_ff[MAG_W-2:0], ge};
         rem_in = ge ? diff[7:0] : trial[7:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      neg_ff <= neg_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign busy     = busy_ff;

endmodule

[rtl/hgf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgf_ctrl
// Sequencer for cell writes, fade ticks and LED renders; owns both handshakes.
// ----------------------------------------------------------------------------
module hgf_ctrl
   import hgf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_src = RD_ITEM;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.cnt_clr = 1'b1;
            cmd.acc_clr = 1'b1;
            case (sts.mode)
               MODE_WRITE: begin
                  if (sts.len_zero) begin
                     cmd.wr_direct = 1'b1;
                     state_in      = ST_FIN;
                  end else begin
                     state_in = ST_WR_RD;
                  end
               end
               MODE_TICK:   state_in = sts.fade_active ? ST_TK_RD : ST_FIN;
               MODE_RENDER: state_in = sts.px_zero ? ST_FIN : ST_RN_RD;
               default:     state_in = ST_FIN;
            endcase
         end
         ST_WR_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_WR_DIV;
         end
         ST_WR_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WR_WT;
         end
         ST_WR_WT: begin
            if (!sts.div_busy) begin
               cmd.step_wr = 1'b1;
               state_in    = ST_FIN;
            end
         end
         ST_TK_RD: begin
            cmd.rd     = 1'b1;
            cmd.rd_src = RD_COUNT;
            state_in   = ST_TK_MUL;
         end
         ST_TK_MUL: begin
            cmd.tk_mul = 1'b1;
            state_in   = ST_TK_WR;
         end
         ST_TK_WR: begin
            cmd.tk_wr   = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (sts.cnt_last) begin
               cmd.tk_end = 1'b1;
               state_in   = ST_FIN;
            end else begin
               state_in = ST_TK_RD;
            end
         end
         ST_RN_RD: begin
            cmd.rd     = 1'b1;
            cmd.rd_src = RD_CORNER;
            cmd.rn_wgt = 1'b1;
            state_in   = ST_RN_MAC;
         end
         ST_RN_MAC: begin
            cmd.rn_mac  = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_in    = sts.corner_last ? ST_HSV1 : ST_RN_RD;
         end
         ST_HSV1: begin
            cmd.hsv1 = 1'b1;
            state_in = ST_HSV2;
         end
         ST_HSV2: begin
            cmd.hsv2 = 1'b1;
            state_in = ST_HSV3;
         end
         ST_HSV3: begin
            cmd.hsv3 = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_ld = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_ld) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/hgf_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgf_datapath
// Cell and step stores, fade step division, tick update, bilinear blend and
// HSV to RGB conversion.
// ----------------------------------------------------------------------------
module hgf_datapath
   import hgf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_cell_x,
   input  logic [2:0]  req_cell_y,
   input  logic [15:0] req_hue,
   input  logic [15:0] req_saturation,
   input  logic [15:0] req_brightness,
   input  logic [15:0] req_pos_x,
   input  logic [15:0] req_pos_y,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_led_present,
   output logic        rsp_fade_busy
);

   logic [1:0]  mode_ff;
   logic [2:0]  cx_ff, cy_ff;
   logic [15:0] th_ff, ts_ff, tv_ff, px_ff, py_ff;
   logic [7:0]  len_ff;
   logic        active_ff;
   logic [7:0]  ticks_ff;
   logic [ADDR_W-1:0] cnt_ff;

   logic [47:0] cell_mem [CELLS];
   logic [71:0] step_mem [CELLS];
   logic [CELLS-1:0] cell_vld_ff, step_vld_ff;
   logic [47:0] cell_rd_ff;
   logic [71:0] step_rd_ff;
   logic        cvld_rd_ff, svld_rd_ff;

   logic [15:0] ch_e, cs_e, cv_e;
   logic signed [STEP_W-1:0] sh_e, ss_e, sv_e;

   logic              in_range;
   logic [ADDR_W-1:0] item_addr, corner_addr, rd_addr, waddr;
   logic              cell_we, step_we;
   logic [47:0]       wdata;

   logic [15:0]  dh16;
   logic [16:0]  ds17, dv17;
   logic signed [STEP_W-1:0] qh, qs, qv;
   logic         bh, bs, bv;

   logic signed [32:0] ph_ff, ps_ff, pv_ff;
   logic signed [18:0] inc_h, inc_s, inc_v;
   logic [47:0]        tick_new;
   logic [8:0]         t1;

   logic [16+X_W-1:0] ox;
   logic [16+Y_W-1:0] oy;
   logic [X_W:0]      x1, x2, xs;
   logic [Y_W:0]      y1, y2, ys;
   logic [16:0]       wx, wy, wxk, wyk;
   logic [32:0]       wgt_ff;
   logic [47:0]       acc_h_ff, acc_s_ff, acc_v_ff;

   logic [18:0] h6;
   logic [15:0] f;
   logic [32:0] pm, sfm, sgm, qm, tm;
   logic [2:0]  sector_ff;
   logic [15:0] v_ff, p_ff, sf_ff, sg_ff, q_ff, t_ff;
   logic [15:0] rx, gx, bx;
   logic [7:0]  rb_ff, gb_ff, bb_ff;
   logic        show;

   function automatic logic signed [18:0] tick_inc(input logic signed [STEP_W-1:0] s,
                                                   input logic signed [32:0] p);
      logic signed [33:0] q;
      logic signed [33:0] d;
      q = 34'(p) + 34'(s);
      d = (q >>> 7) - (34'(p) >>> 7);
      return d[18:0];
   endfunction

   function automatic logic [15:0] sat16(input logic [15:0] c, input logic signed [18:0] i);
      logic signed [18:0] s;
      s = $signed({3'b000, c}) + i;
      if (s < 0) return 16'd0;
      if (s > 19'sd65535) return 16'hFFFF;
      return s[15:0];
   endfunction

   function automatic logic [7:0] to_byte(input logic [15:0] x);
      logic [23:0] m;
      m = {x, 8'd0} - {8'd0, x};
      return (m[23:16] > 8'd255) ? 8'd255 : m[23:16];
   endfunction

   // item and configuration
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         cx_ff   <= req_cell_x;
         cy_ff   <= req_cell_y;
         th_ff   <= req_hue;
         ts_ff   <= req_saturation;
         tv_ff   <= req_brightness;
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (csr_wr_en) begin
         len_ff <= csr_wr_data;
      end
   end

   // addressing
   assign in_range  = ({1'b0, cx_ff} < 4'(GRID_WIDTH)) && ({1'b0, cy_ff} < 4'(GRID_HEIGHT));
   assign item_addr = ADDR_W'(cy_ff) * ADDR_W'(GRID_WIDTH) + ADDR_W'(cx_ff);

   assign ox = (16+X_W)'(px_ff) * (16+X_W)'(GRID_WIDTH - 1);
   assign oy = (16+Y_W)'(py_ff) * (16+Y_W)'(GRID_HEIGHT - 1);
   assign wx = {1'b0, ox[15:0]};
   assign wy = {1'b0, oy[15:0]};

   always_comb begin
      x1 = {1'b0, ox[16 +: X_W]};
      y1 = {1'b0, oy[16 +: Y_W]};
      if (x1 > (X_W+1)'(GRID_WIDTH - 1))  x1 = (X_W+1)'(GRID_WIDTH - 1);
      if (y1 > (Y_W+1)'(GRID_HEIGHT - 1)) y1 = (Y_W+1)'(GRID_HEIGHT - 1);
      x2 = x1 + 1'b1;
      y2 = y1 + 1'b1;
      if (x2 > (X_W+1)'(GRID_WIDTH - 1))  x2 = (X_W+1)'(GRID_WIDTH - 1);
      if (y2 > (Y_W+1)'(GRID_HEIGHT - 1)) y2 = (Y_W+1)'(GRID_HEIGHT - 1);
      xs  = cnt_ff[0] ? x2 : x1;
      ys  = cnt_ff[1] ? y2 : y1;
      wxk = cnt_ff[0] ? wx : (17'h10000 - wx);
      wyk = cnt_ff[1] ? wy : (17'h10000 - wy);
   end

   assign corner_addr = ADDR_W'(ys) * ADDR_W'(GRID_WIDTH) + ADDR_W'(xs);

   always_comb begin
      case (cmd.rd_src)
         RD_ITEM:   rd_addr = item_addr;
         RD_COUNT:  rd_addr = cnt_ff;
         RD_CORNER: rd_addr = corner_addr;
         default:   rd_addr = item_addr;
      endcase
   end

   // stores
   assign cell_we = (cmd.wr_direct && in_range) || cmd.tk_wr;
   assign waddr   = cmd.tk_wr ? cnt_ff : item_addr;
   assign wdata   = cmd.tk_wr ? tick_new : {th_ff, ts_ff, tv_ff};
   assign step_we = cmd.step_wr && in_range;

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[waddr] <= wdata;
      end
      if (step_we) begin
         step_mem[item_addr] <= {qh, qs, qv};
      end
      if (cmd.rd) begin
         cell_rd_ff <= cell_mem[rd_addr];
         step_rd_ff <= step_mem[rd_addr];
         cvld_rd_ff <= cell_vld_ff[rd_addr];
         svld_rd_ff <= step_vld_ff[rd_addr];
      end
   end

   assign t1 = {1'b0, ticks_ff} + 9'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_vld_ff <= '0;
         step_vld_ff <= '0;
         active_ff   <= 1'b0;
         ticks_ff    <= '0;
      end else begin
         if (cell_we) begin
            cell_vld_ff[waddr] <= 1'b1;
         end
         if (step_we) begin
            step_vld_ff[item_addr] <= 1'b1;
            active_ff              <= 1'b1;
            ticks_ff               <= '0;
         end else if (cmd.wr_direct && in_range) begin
            step_vld_ff[item_addr] <= 1'b0;
         end else if (cmd.tk_end) begin
            ticks_ff <= t1[7:0];
            if (t1 >= {1'b0, len_ff}) begin
               active_ff   <= 1'b0;
               step_vld_ff <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cnt_clr) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign ch_e = cvld_rd_ff ? cell_rd_ff[47:32] : 16'd0;
   assign cs_e = cvld_rd_ff ? cell_rd_ff[31:16] : 16'd0;
   assign cv_e = cvld_rd_ff ? cell_rd_ff[15:0]  : 16'd0;
   assign sh_e = svld_rd_ff ? $signed(step_rd_ff[71:48]) : '0;
   assign ss_e = svld_rd_ff ? $signed(step_rd_ff[47:24]) : '0;
   assign sv_e = svld_rd_ff ? $signed(step_rd_ff[23:0])  : '0;

   // fade step
   assign dh16 = th_ff - ch_e;
   assign ds17 = {1'b0, ts_ff} - {1'b0, cs_e};
   assign dv17 = {1'b0, tv_ff} - {1'b0, cv_e};

   hgf_div u_div_h (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ($signed({dh16[15], dh16, 7'd0})),
      .divisor  (len_ff),
      .quotient (qh),
      .busy     (bh)
   );

   hgf_div u_div_s (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ($signed({ds17, 7'd0})),
      .divisor  (len_ff),
      .quotient (qs),
      .busy     (bs)
   );

   hgf_div u_div_v (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ($signed({dv17, 7'd0})),
      .divisor  (len_ff),
      .quotient (qv),
      .busy     (bv)
   );

   // fade tick
   always_ff @(posedge clock) begin
      if (cmd.tk_mul) begin
         ph_ff <= sh_e * $signed({1'b0, ticks_ff});
         ps_ff <= ss_e * $signed({1'b0, ticks_ff});
         pv_ff <= sv_e * $signed({1'b0, ticks_ff});
      end
   end

   assign inc_h    = tick_inc(sh_e, ph_ff);
   assign inc_s    = tick_inc(ss_e, ps_ff);
   assign inc_v    = tick_inc(sv_e, pv_ff);
   assign tick_new = {ch_e + inc_h[15:0], sat16(cs_e, inc_s), sat16(cv_e, inc_v)};

   // bilinear blend
   always_ff @(posedge clock) begin
      if (cmd.rn_wgt) begin
         wgt_ff <= 33'(wxk * wyk);
      end
      if (cmd.acc_clr) begin
         acc_h_ff <= '0;
         acc_s_ff <= '0;
         acc_v_ff <= '0;
      end else if (cmd.rn_mac) begin
         acc_h_ff <= acc_h_ff + 48'(ch_e * wgt_ff);
         acc_s_ff <= acc_s_ff + 48'(cs_e * wgt_ff);
         acc_v_ff <= acc_v_ff + 48'(cv_e * wgt_ff);
      end
   end

   // HSV to RGB
   assign h6  = 19'(acc_h_ff[47:32]) * 19'd6;
   assign f   = h6[15:0];
   assign pm  = 33'(acc_v_ff[47:32]) * (33'h10000 - 33'(acc_s_ff[47:32]));
   assign sfm = 33'(acc_s_ff[47:32]) * 33'(f);
   assign sgm = 33'(acc_s_ff[47:32]) * (33'h10000 - 33'(f));
   assign qm  = 33'(v_ff) * (33'h10000 - 33'(sf_ff));
   assign tm  = 33'(v_ff) * (33'h10000 - 33'(sg_ff));

   always_ff @(posedge clock) begin
      if (cmd.hsv1) begin
         sector_ff <= h6[18:16];
         v_ff      <= acc_v_ff[47:32];
         p_ff      <= pm[31:16];
         sf_ff     <= sfm[31:16];
         sg_ff     <= sgm[31:16];
      end
      if (cmd.hsv2) begin
         q_ff <= qm[31:16];
         t_ff <= tm[31:16];
      end
   end

   always_comb begin
      case (sector_ff)
         3'd0:    begin rx = v_ff; gx = t_ff; bx = p_ff; end
         3'd1:    begin rx = q_ff; gx = v_ff; bx = p_ff; end
         3'd2:    begin rx = p_ff; gx = v_ff; bx = t_ff; end
         3'd3:    begin rx = p_ff; gx = q_ff; bx = v_ff; end
         3'd4:    begin rx = t_ff; gx = p_ff; bx = v_ff; end
         default: begin rx = v_ff; gx = p_ff; bx = q_ff; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.hsv3) begin
         rb_ff <= to_byte(rx);
         gb_ff <= to_byte(gx);
         bb_ff <= to_byte(bx);
      end
   end

   // result beat
   assign show = (mode_ff == MODE_RENDER) && (px_ff != 16'd0);

   always_ff @(posedge clock) begin
      if (cmd.out_ld) begin
         rsp_red         <= show ? rb_ff : 8'd0;
         rsp_green       <= show ? gb_ff : 8'd0;
         rsp_blue        <= show ? bb_ff : 8'd0;
         rsp_led_present <= show;
         rsp_fade_busy   <= active_ff;
      end
   end

   assign sts.mode        = mode_ff;
   assign sts.len_zero    = (len_ff == 8'd0);
   assign sts.fade_active = active_ff;
   assign sts.px_zero     = (px_ff == 16'd0);
   assign sts.div_busy    = bh | bs | bv;
   assign sts.cnt_last    = (cnt_ff == ADDR_W'(CELLS - 1));
   assign sts.corner_last = (cnt_ff[1:0] == 2'd3);

endmodule

[rtl/hsv_grid_fade_bilinear_led_render_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_grid_fade_bilinear_led_render_core
// Steps: direct write stored at decode; fading write reads the cell, waits
// on the step dividers; fade tick visits all 64 cells in turn (one store
// port); render does four corner reads then three multiply stages.
// Throughput: one beat at a time; the next beat is taken on return to idle.
// Reset: synchronous; grid, steps, fade state and fade length read as zero.
// ----------------------------------------------------------------------------
module hsv_grid_fade_bilinear_led_render_core
   import hgf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_cell_x,
   input  logic [2:0]  req_cell_y,
   input  logic [15:0] req_hue,
   input  logic [15:0] req_saturation,
   input  logic [15:0] req_brightness,
   input  logic [15:0] req_pos_x,
   input  logic [15:0] req_pos_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_led_present,
   output logic        rsp_fade_busy,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   hgf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   hgf_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_mode        (req_mode),
      .req_cell_x      (req_cell_x),
      .req_cell_y      (req_cell_y),
      .req_hue         (req_hue),
      .req_saturation  (req_saturation),
      .req_brightness  (req_brightness),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_led_present (rsp_led_present),
      .rsp_fade_busy   (rsp_fade_busy)
   );

endmodule
